>>> design/pcpa_pkg.sv
// Shared types and constants for the per-CPU page free-list allocator.
// Used by the divider and the top level.
`default_nettype none

package pcpa_pkg;

   localparam int NUM_CPUS   = 8;
   localparam int MAX_PAGES  = 32768;
   localparam int PAGE_BITS  = 12;

   localparam int ADDR_W     = 32;
   localparam int LINK_W     = 16;
   localparam int CPU_REQ_W  = 4;
   localparam int CPU_W      = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
   localparam int IDX_W      = $clog2(MAX_PAGES);
   localparam int IDX_FULL_W = ADDR_W - PAGE_BITS;
   localparam int DIV_CNT_W  = $clog2(ADDR_W);

   localparam logic [ADDR_W-1:0] REGION_START_RST = 32'h8000_0000;
   localparam logic [ADDR_W-1:0] REGION_END_RST   = 32'h8800_0000;

   localparam int             CSR_IDX_W        = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_START = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_END   = 1'b1;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_EMPTY   = 2'd1,
      STAT_BADADDR = 2'd2
   } pcpa_status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FCHECK,
      S_LSTART,
      S_LDIV,
      S_PUSH,
      S_ATRY,
      S_AWAIT
   } pcpa_state_type;

   typedef struct packed {
      logic              start;
      logic [ADDR_W-1:0] dividend;
      logic [ADDR_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [ADDR_W-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

>>> design/pcpa_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on pcpa_pkg for widths and the request/response structs.
`default_nettype none

module pcpa_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire pcpa_pkg::div_req_type div_req,
   output pcpa_pkg::div_rsp_type      div_rsp
);
   import pcpa_pkg::*;

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [ADDR_W-1:0]    rem_ff;
   logic [ADDR_W-1:0]    rem_in;
   logic [ADDR_W-1:0]    quo_ff;
   logic [ADDR_W-1:0]    quo_in;
   logic [ADDR_W-1:0]    dvs_ff;
   logic [ADDR_W:0]      trial;
   logic [ADDR_W:0]      diff;
   logic                 ge;

   always_comb begin
      trial  = {rem_ff, quo_ff[ADDR_W-1]};
      ge     = trial >= {1'b0, dvs_ff};
      diff   = trial - {1'b0, dvs_ff};
      // remainder stays below the divisor, so the top bit drops out
      rem_in = ge ? diff[ADDR_W-1:0] : trial[ADDR_W-1:0];
      quo_in = {quo_ff[ADDR_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_CNT_W'(ADDR_W - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - DIV_CNT_W'(1);
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff <= '0;
         quo_ff <= div_req.dividend;
         dvs_ff <= div_req.divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

`default_nettype wire

>>> design/pcpa_link_ram.sv
// Single-port-write, single-port-read RAM with registered read data.
// Holds the next-link of every page; no dependencies.
`default_nettype none

module pcpa_link_ram #(
   parameter int DEPTH  = 32768,
   parameter int WIDTH  = 16,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> design/per_cpu_page_free_list_allocator.sv
// Sequence: an alloc checks its own list head, then reads the link of the page it takes; an
//   empty own list starts a scan from the first list, up to NUM_CPUS lists. A free checks the
//   address (a bad one ends it), then waits on the 32-step divider, skipped for block size zero.
// One request at a time: the next word is taken at the edge that takes the result.
// Reset (synchronous): lists empty, region registers to their reset values,
//   link table left uninitialized, no clearing pass.
`default_nettype none

module per_cpu_page_free_list_allocator (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // [3:0] requester_cpu, [35:4] page_addr, zero pad
   input  wire logic [0:0]  req_tuser,   // [0] req_type
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [31:0] rsp_tdata,   // [31:0] granted_addr
   output logic      [1:0]  rsp_tuser,   // [1:0] status
   // register write channel
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [pcpa_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0] csr_data
);
   import pcpa_pkg::*;

   pcpa_state_type    state_ff, state_in;

   logic [ADDR_W-1:0] start_ff, start_in;
   logic [ADDR_W-1:0] end_ff, end_in;
   logic [ADDR_W-1:0] bsize_ff, bsize_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [CPU_W-1:0]  cur_ff, cur_in;
   logic              scan_ff, scan_in;
   logic [LINK_W-1:0] hold_ff, hold_in;
   logic [LINK_W-1:0] heads_ff [NUM_CPUS];
   logic [LINK_W-1:0] heads_in [NUM_CPUS];

   logic              rsp_valid_ff, rsp_valid_in;
   pcpa_status_type   rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;

   logic              req_accept;
   logic              csr_accept;
   logic [ADDR_W:0]   base;
   logic [ADDR_W:0]   offset;
   logic [IDX_FULL_W-1:0] idx_full;
   logic              bad_addr;
   logic [LINK_W-1:0] head_cur;
   logic              last_cpu;

   div_req_type       div_req;
   div_rsp_type       div_rsp;

   logic              link_we;
   logic [IDX_W-1:0]  link_waddr;
   logic [LINK_W-1:0] link_wdata;
   logic              link_re;
   logic [IDX_W-1:0]  link_raddr;
   logic [LINK_W-1:0] link_rdata;

   pcpa_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   pcpa_link_ram #(
      .DEPTH  (MAX_PAGES),
      .WIDTH  (LINK_W),
      .ADDR_W (IDX_W)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_en   (link_re),
      .rd_addr (link_raddr),
      .rd_data (link_rdata)
   );

   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid && csr_ready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_addr_ff;
   assign rsp_tuser  = rsp_status_ff;

   // page base: region_start rounded up to a page boundary, may carry past 32 bits
   always_comb begin
      base     = ({1'b0, start_ff} + (ADDR_W+1)'((1 << PAGE_BITS) - 1))
                 & ~(ADDR_W+1)'((1 << PAGE_BITS) - 1);
      offset   = {1'b0, addr_ff} - base;
      idx_full = offset[ADDR_W-1:PAGE_BITS];
      bad_addr = (addr_ff[PAGE_BITS-1:0] != '0) || (addr_ff < start_ff)
                 || (addr_ff >= end_ff) || (idx_full >= IDX_FULL_W'(MAX_PAGES));
      head_cur = heads_ff[cur_ff];
      last_cpu = cur_ff == CPU_W'(NUM_CPUS - 1);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = req_tuser[0] ? S_FCHECK : S_ATRY;
            end
         end
         S_FCHECK: begin
            if (bad_addr) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_LSTART;
            end
         end
         S_LSTART: begin
            state_in = (bsize_ff == '0) ? S_PUSH : S_LDIV;
         end
         S_LDIV: begin
            if (div_rsp.done) begin
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            state_in = S_IDLE;
         end
         S_ATRY: begin
            if (head_cur != '0) begin
               state_in = S_AWAIT;
            end else if (scan_ff && last_cpu) begin
               state_in = S_IDLE;
            end
         end
         S_AWAIT: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // datapath and strobes
   always_comb begin
      start_in      = start_ff;
      end_in        = end_ff;
      bsize_in      = bsize_ff;
      addr_in       = addr_ff;
      cur_in        = cur_ff;
      scan_in       = scan_ff;
      hold_in       = hold_ff;
      heads_in      = heads_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      div_req       = '0;
      link_we       = 1'b0;
      link_waddr    = idx_full[IDX_W-1:0];
      link_wdata    = head_cur;
      link_re       = 1'b0;
      link_raddr    = IDX_W'(head_cur - LINK_W'(1));

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               addr_in = req_tdata[35:4];
               if ({1'b0, req_tdata[3:0]} < (CPU_REQ_W+1)'(NUM_CPUS)) begin
                  cur_in  = CPU_W'(req_tdata[3:0]);
                  scan_in = 1'b0;
               end else begin
                  cur_in  = '0;
                  scan_in = 1'b1;
               end
            end
         end
         S_FCHECK: begin
            if (bad_addr) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_BADADDR;
               rsp_addr_in   = '0;
            end else begin
               // block size per list; the list count is a power of two
               bsize_in = (end_ff - start_ff) / ADDR_W'(NUM_CPUS);
            end
         end
         S_LSTART: begin
            if (bsize_ff == '0) begin
               cur_in = CPU_W'(NUM_CPUS - 1);
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = addr_ff - start_ff;
               div_req.divisor  = bsize_ff;
            end
         end
         S_LDIV: begin
            if (div_rsp.done) begin
               // saturate list number at the last CPU
               if (div_rsp.quotient >= ADDR_W'(NUM_CPUS)) begin
                  cur_in = CPU_W'(NUM_CPUS - 1);
               end else begin
                  cur_in = div_rsp.quotient[CPU_W-1:0];
               end
            end
         end
         S_PUSH: begin
            link_we          = 1'b1;
            heads_in[cur_ff] = LINK_W'(idx_full) + LINK_W'(1);
            rsp_valid_in     = 1'b1;
            rsp_status_in    = STAT_OK;
            rsp_addr_in      = '0;
         end
         S_ATRY: begin
            if (head_cur != '0) begin
               link_re = 1'b1;
               hold_in = head_cur;
            end else if (scan_ff) begin
               if (last_cpu) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STAT_EMPTY;
                  rsp_addr_in   = '0;
               end else begin
                  cur_in = cur_ff + CPU_W'(1);
               end
            end else begin
               // own list empty: steal, scanning from the first list
               cur_in  = '0;
               scan_in = 1'b1;
            end
         end
         S_AWAIT: begin
            heads_in[cur_ff] = link_rdata;
            rsp_valid_in     = 1'b1;
            rsp_status_in    = STAT_OK;
            rsp_addr_in      = base[ADDR_W-1:0]
                               + (ADDR_W'(hold_ff - LINK_W'(1)) << PAGE_BITS);
         end
         default: begin
         end
      endcase

      if (csr_accept) begin
         if (csr_index == CSR_REGION_START) begin
            start_in = csr_data;
         end else if (csr_index == CSR_REGION_END) begin
            end_in = csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         start_ff     <= REGION_START_RST;
         end_ff       <= REGION_END_RST;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CPUS; i++) begin
            heads_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         end_ff       <= end_in;
         rsp_valid_ff <= rsp_valid_in;
         heads_ff     <= heads_in;
      end
   end

   always_ff @(posedge clock) begin
      bsize_ff      <= bsize_in;
      addr_ff       <= addr_in;
      cur_ff        <= cur_in;
      scan_ff       <= scan_in;
      hold_ff       <= hold_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

`ifndef SYNTHESIS
   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_LDIV))
      else $error("divider finished outside a divide wait");

   a_pop_nonnull: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_AWAIT) |-> (hold_ff != '0) && ($past(state_ff) == S_ATRY))
      else $error("link read issued for an empty list");

   a_fail_zero_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != STAT_OK) |-> (rsp_tdata == '0))
      else $error("failed request carries a nonzero address");

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready)
      else $error("request taken while one is in flight");
`endif

endmodule

`default_nettype wire
